// ===== design/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, constants and address helpers for the set-associative cache.
// ----------------------------------------------------------------------------
`default_nettype none
package sac_pkg;

  localparam int unsigned Sets      = 64;
  localparam int unsigned SetBits   = $clog2(Sets);
  localparam int unsigned Ways      = 8;
  localparam int unsigned WayBits   = $clog2(Ways);
  localparam int unsigned AddrBits  = 48;
  localparam int unsigned StampBits = 32;

  // Configuration register indexes.
  localparam logic [2:0] RegOffsetBits = 3'd0;
  localparam logic [2:0] RegIndexBits  = 3'd1;
  localparam logic [2:0] RegWaysInUse  = 3'd2;
  localparam logic [2:0] RegLruMode    = 3'd3;
  localparam logic [2:0] RegPrefetchEn = 3'd4;

  typedef struct packed {
    logic                 valid;
    logic [AddrBits-1:0]  tag;
    logic [StampBits-1:0] stamp;
  } way_t;

  typedef way_t [Ways-1:0] row_t;

  // Set index: bits above the block offset, masked to the sets in use.
  function automatic logic [SetBits-1:0] set_of(logic [AddrBits-1:0] addr,
                                                logic [3:0] ob, logic [2:0] ib);
    logic [AddrBits-1:0] sel;
    logic [7:0]          mask;
    sel  = addr >> ob;
    mask = (8'd1 << ib) - 8'd1;
    return SetBits'(sel[7:0] & mask);
  endfunction

  // Tag: all bits above offset and index.
  function automatic logic [AddrBits-1:0] tag_of(logic [AddrBits-1:0] addr,
                                                 logic [3:0] ob, logic [2:0] ib);
    logic [4:0] ts;
    ts = 5'(ob) + 5'(ib);
    return addr >> ts;
  endfunction

endpackage
`default_nettype wire

// ===== design/set_assoc_cache_with_prefetch.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_with_prefetch
// Write-through, write-allocate set-associative cache tag model with FIFO or
// LRU replacement and next-line prefetch on demand misses.
// ----------------------------------------------------------------------------
// Channel  | Handshake                  | Payload
// input    | in_valid_i / in_stall_o    | kind_i, address_i
// output   | out_valid_o / out_stall_i  | hit_o, mem_reads_o, mem_write_o,
//          |                            | prefetch_filled_o
// config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A word passes the Idle, Look and Fin states on a hit or a miss without
// prefetch, and also PfRd and PfLk when the prefetch lookup runs; the single
// row read port of the set memory sets this sequence, one row read and at most one row write per lookup.
// Reset clears the per-row valid flags, so no clearing pass is needed.
// A finished word waits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_with_prefetch
  import sac_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                kind_i,
  input  wire logic [AddrBits-1:0] address_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                hit_o,
  output      logic [1:0]          mem_reads_o,
  output      logic                mem_write_o,
  output      logic                prefetch_filled_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [3:0]          cfg_data_i
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StLook  = 5'b00010,
    StPfRd  = 5'b00100,
    StPfLk  = 5'b01000,
    StFin   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [3:0] ob_q;
  logic [2:0] ib_q;
  logic [3:0] ways_q;
  logic       lru_q;
  logic       pf_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_q    <= 4'd6;
      ib_q    <= 3'd6;
      ways_q  <= 4'd8;
      lru_q   <= 1'b0;
      pf_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegOffsetBits: ob_q    <= cfg_data_i;
        RegIndexBits:  ib_q    <= cfg_data_i[2:0];
        RegWaysInUse:  ways_q  <= cfg_data_i;
        RegLruMode:    lru_q   <= cfg_data_i[0];
        RegPrefetchEn: pf_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Work registers.
  logic [AddrBits-1:0]  addr_q, addr_d;
  logic                 kind_q, kind_d;
  logic                 hit_q, hit_d;
  logic [1:0]           reads_q, reads_d;
  logic                 pf_q, pf_d;
  logic [StampBits-1:0] stamp_q, stamp_d;
  logic [Sets-1:0]      row_ok_q, row_ok_d;
  logic                 rd_ok_q;
  logic                 out_valid_q, out_valid_d;
  logic                 o_hit_q, o_kind_q, o_pf_q;
  logic [1:0]           o_reads_q;

  // Set memory: one row holds every way of a set.
  logic                ram_we;
  logic [SetBits-1:0]  ram_waddr, ram_raddr;
  row_t                ram_wdata, ram_rdata, row;

  sac_ram #(
    .Width($bits(row_t)),
    .Depth(Sets)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic accept;
  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);

  // A row never written reads as all zero.
  assign row = rd_ok_q ? ram_rdata : '0;

  // Lookup on the current row.
  logic [SetBits-1:0]  set_c;
  logic [AddrBits-1:0] tag_c;
  logic [3:0]          ways_act;
  logic [Ways-1:0]     act, hit_vec;
  logic                hit_c, open_found;
  logic [WayBits-1:0]  open_way, hit_way, victim, sel_way;
  logic [StampBits-1:0] key [WayBits+1][Ways];
  logic [WayBits-1:0]   kix [WayBits+1][Ways];

  always_comb begin
    set_c    = set_of(addr_q, ob_q, ib_q);
    tag_c    = tag_of(addr_q, ob_q, ib_q);
    ways_act = (ways_q == 4'd0) ? 4'd1 : ((ways_q > 4'(Ways)) ? 4'(Ways) : ways_q);
    open_found = 1'b0;
    open_way   = '0;
    hit_way    = '0;
    for (int w = 0; w < Ways; w++) begin
      act[w]     = (4'(w) < ways_act);
      hit_vec[w] = act[w] && row[w].valid && (row[w].tag == tag_c);
      if (act[w] && !row[w].valid) begin
        open_found = 1'b1;
        open_way   = WayBits'(w);
      end
    end
    // The lowest matching way wins, as a tag can repeat after a geometry change.
    for (int w = Ways - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WayBits'(w);
      end
    end
    hit_c = |hit_vec;
    // Minimum stamp tree; ties go to the lower way, unused ways never win.
    for (int w = 0; w < Ways; w++) begin
      key[0][w] = act[w] ? row[w].stamp : '1;
      kix[0][w] = WayBits'(w);
    end
    for (int l = 0; l < WayBits; l++) begin
      for (int w = 0; w < Ways; w++) begin
        key[l+1][w] = key[l][w];
        kix[l+1][w] = kix[l][w];
      end
      for (int w = 0; w < (Ways >> (l + 1)); w++) begin
        if (key[l][2*w+1] < key[l][2*w]) begin
          key[l+1][w] = key[l][2*w+1];
          kix[l+1][w] = kix[l][2*w+1];
        end else begin
          key[l+1][w] = key[l][2*w];
          kix[l+1][w] = kix[l][2*w];
        end
      end
    end
    victim  = kix[WayBits][0];
    sel_way = hit_c ? hit_way : (open_found ? open_way : victim);
  end

  // Control and row update.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    kind_d      = kind_q;
    hit_d       = hit_q;
    reads_d     = reads_q;
    pf_d        = pf_q;
    stamp_d     = stamp_q;
    row_ok_d    = row_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = set_c;
    ram_wdata   = row;
    ram_raddr   = set_of(address_i, ob_q, ib_q);
    ram_wdata[sel_way].valid = 1'b1;
    ram_wdata[sel_way].tag   = tag_c;
    ram_wdata[sel_way].stamp = stamp_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          addr_d  = address_i;
          kind_d  = kind_i;
          reads_d = 2'd0;
          pf_d    = 1'b0;
          state_d = StLook;
        end
      end
      StLook: begin
        hit_d = hit_c;
        if (!hit_c || lru_q) begin
          ram_we  = 1'b1;
          stamp_d = stamp_q + 1'b1;
          row_ok_d[set_c] = 1'b1;
        end
        if (!hit_c) begin
          reads_d = 2'd1;
        end
        if (!hit_c && pf_en_q) begin
          addr_d  = addr_q + (AddrBits'(1) << ob_q);
          state_d = StPfRd;
        end else begin
          state_d = StFin;
        end
      end
      StPfRd: begin
        ram_raddr = set_c;
        state_d   = StPfLk;
      end
      StPfLk: begin
        if (!hit_c) begin
          ram_we  = 1'b1;
          stamp_d = stamp_q + 1'b1;
          row_ok_d[set_c] = 1'b1;
          reads_d = 2'd2;
          pf_d    = 1'b1;
        end
        state_d = StFin;
      end
      StFin: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      stamp_q     <= StampBits'(1);
      row_ok_q    <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stamp_q     <= stamp_d;
      row_ok_q    <= row_ok_d;
      rd_ok_q     <= row_ok_q[ram_raddr];
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    kind_q  <= kind_d;
    hit_q   <= hit_d;
    reads_q <= reads_d;
    pf_q    <= pf_d;
    if (state_q == StFin && (!out_valid_q || !out_stall_i)) begin
      o_hit_q   <= hit_q;
      o_kind_q  <= kind_q;
      o_reads_q <= reads_q;
      o_pf_q    <= pf_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = o_hit_q;
  assign mem_reads_o       = o_reads_q;
  assign mem_write_o       = o_kind_q;
  assign prefetch_filled_o = o_pf_q;

  // A hit never reads memory.
  a_hit_no_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!hit_o || mem_reads_o == 2'd0))
    else $error("hit with memory reads");

  // A prefetch fill always comes with two reads.
  a_pf_two_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!prefetch_filled_o || mem_reads_o == 2'd2))
    else $error("prefetch fill without two reads");

  // The prefetch lookup only follows a demand miss with prefetch on.
  a_pf_after_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPfRd) |-> ($past(state_q) == StLook && reads_q == 2'd1 && pf_en_q))
    else $error("prefetch without demand miss");

  // An accepted word moves on to the lookup.
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StLook))
    else $error("accepted word not looked up");

endmodule
`default_nettype wire

// ===== design/sac_ram.sv =====
// ----------------------------------------------------------------------------
// sac_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache testbench
// Drives read and write accesses into the cache tag model under several
// geometry, replacement and prefetch settings. A behavioral copy of the tag
// store predicts hit, memory reads, memory write and prefetch fill for every
// accepted word. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench
  import sac_pkg::*;
;

  // Index past the end of the register list; the block ignores it.
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned ItemsPerPhase = 50;
  localparam int unsigned SettleCycles = 12;

  typedef struct {
    logic       hit;
    logic [1:0] reads;
    logic       wr;
    logic       pf;
  } cache_result_t;

  typedef struct {
    logic                kind;
    logic [AddrBits-1:0] addr;
    bit                  typed;
    logic                hit;
    logic [1:0]          reads;
    logic                pf;
  } access_row_t;

  typedef struct {
    logic [3:0] ob;
    logic [2:0] ib;
    logic [3:0] ways;
    logic       lru;
    logic       pf;
    bit         no_idle;
  } cache_setting_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                kind_i = 1'b0;
  logic [AddrBits-1:0] address_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                hit_o;
  logic [1:0]          mem_reads_o;
  logic                mem_write_o;
  logic                prefetch_filled_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [3:0]          cfg_data_i = '0;

  set_assoc_cache_with_prefetch dut (.*);

  always #10 clk_i = ~clk_i;

  // Shadow copy of the tag store and its settings.
  logic [AddrBits-1:0]  shadow_tag [Sets*Ways];
  logic                 shadow_valid [Sets*Ways];
  logic [StampBits-1:0] shadow_stamp [Sets*Ways];
  logic [StampBits-1:0] stamp_ctr;
  logic [3:0] set_ob;
  logic [2:0] set_ib;
  logic [3:0] set_ways;
  logic       set_lru;
  logic       set_pf;

  cache_result_t pending_results[$];
  int unsigned   error_count = 0;
  int unsigned   idle_cycles = 0;
  bit            quiet_sender = 1'b0;
  bit            quiet_receiver = 1'b0;
  int unsigned   stall_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Looks up one block; fills it on a miss. Returns 1 on a hit.
  function automatic bit probe_block(input logic [AddrBits-1:0] a, input bit restamp);
    logic [AddrBits-1:0] sel;
    logic [AddrBits-1:0] tg;
    int unsigned set_idx;
    int unsigned base;
    int unsigned nways;
    int open_way;
    int unsigned victim;
    sel = a >> set_ob;
    set_idx = int'(sel & ((48'd1 << set_ib) - 48'd1)) % Sets;
    tg = a >> (int'(set_ob) + int'(set_ib));
    nways = (set_ways == 0) ? 1 : (set_ways > Ways) ? Ways : set_ways;
    base = set_idx * Ways;
    open_way = -1;
    for (int w = 0; w < nways; w++) begin
      if (!shadow_valid[base+w]) begin
        open_way = w;
      end else if (shadow_tag[base+w] == tg) begin
        if (restamp) begin
          shadow_stamp[base+w] = stamp_ctr;
          stamp_ctr++;
        end
        return 1'b1;
      end
    end
    if (open_way < 0) begin
      victim = 0;
      for (int w = 1; w < nways; w++)
        if (shadow_stamp[base+w] < shadow_stamp[base+victim]) victim = w;
      open_way = victim;
    end
    shadow_tag[base+open_way] = tg;
    shadow_valid[base+open_way] = 1'b1;
    shadow_stamp[base+open_way] = stamp_ctr;
    stamp_ctr++;
    return 1'b0;
  endfunction

  function automatic cache_result_t predict_access(input logic k,
                                                   input logic [AddrBits-1:0] a);
    cache_result_t r;
    logic [AddrBits-1:0] next_addr;
    r.hit = probe_block(a, set_lru);
    r.reads = 2'd0;
    r.pf = 1'b0;
    r.wr = k;
    if (!r.hit) begin
      r.reads = 2'd1;
      if (set_pf) begin
        next_addr = a + (48'd1 << set_ob);
        if (!probe_block(next_addr, 1'b0)) begin
          r.reads = 2'd2;
          r.pf = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Sends one word and records what it should produce.
  task automatic send_access(input access_row_t row);
    cache_result_t r;
    int unsigned pick;
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = row.kind;
    address_i = row.addr;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_access(row.kind, row.addr);
    if (row.typed) begin
      r.hit = row.hit;
      r.reads = row.reads;
      r.pf = row.pf;
      r.wr = row.kind;
    end
    pending_results.push_back(r);
    pick = $urandom_range(0, 99);
    gap = quiet_sender ? 0 : (pick < 50) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                           : $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegOffsetBits: set_ob = data;
      RegIndexBits:  set_ib = data[2:0];
      RegWaysInUse:  set_ways = data;
      RegLruMode:    set_lru = data[0];
      RegPrefetchEn: set_pf = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly a small pool of conflicting and adjacent blocks, some wide noise.
  function automatic logic [AddrBits-1:0] pick_address();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return (48'($urandom_range(0, 11)) << 13) | 48'($urandom_range(0, 63));
    if (sel < 70) return 48'($urandom_range(0, 7)) << $urandom_range(0, 15);
    if (sel < 80) return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4095));
    return {$urandom, $urandom};
  endfunction

  // Receiver stalls: mostly short, a few long, none in quiet stretches.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i = 1'b1;
    end else if (quiet_receiver || $urandom_range(0, 99) < 60) begin
      out_stall_i = 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
      out_stall_i = 1'b1;
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (hit_o !== want.hit)
            report($sformatf("hit %b, want %b", hit_o, want.hit));
          if (mem_reads_o !== want.reads)
            report($sformatf("mem_reads %0d, want %0d", mem_reads_o, want.reads));
          if (mem_write_o !== want.wr)
            report($sformatf("mem_write %b, want %b", mem_write_o, want.wr));
          if (prefetch_filled_o !== want.pf)
            report($sformatf("prefetch_filled %b, want %b", prefetch_filled_o, want.pf));
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired with %0d results pending", pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    access_row_t    directed[$];
    access_row_t    row;
    cache_setting_t phases[$];
    cache_setting_t ph;

    for (int i = 0; i < Sets*Ways; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_stamp[i] = '0;
    end
    stamp_ctr = 32'd1;
    set_ob = 4'd6;
    set_ib = 3'd6;
    set_ways = 4'd8;
    set_lru = 1'b0;
    set_pf = 1'b0;

    // Reset defaults: cold miss then hit at both address extremes.
    directed.push_back('{1'b0, 48'h0, 1'b1, 1'b0, 2'd1, 1'b0});
    directed.push_back('{1'b1, 48'h0, 1'b1, 1'b1, 2'd0, 1'b0});
    directed.push_back('{1'b0, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 2'd1, 1'b0});
    directed.push_back('{1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 2'd0, 1'b0});
    // Nine more tags into set zero force FIFO eviction of the oldest way.
    for (int i = 1; i <= 9; i++)
      directed.push_back('{i[0], 48'(i) << 12, 1'b0, 1'b0, 2'd0, 1'b0});
    directed.push_back('{1'b0, 48'h0, 1'b0, 1'b0, 2'd0, 1'b0});
    directed.push_back('{1'b1, 48'h2000, 1'b0, 1'b0, 2'd0, 1'b0});
    directed.push_back('{1'b0, 48'h1000, 1'b0, 1'b0, 2'd0, 1'b0});
    directed.push_back('{1'b0, 48'h5555_5555_5555, 1'b0, 1'b0, 2'd0, 1'b0});
    directed.push_back('{1'b1, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 2'd0, 1'b0});

    // Settings: defaults with prefetch, LRU, fully associative direct ways,
    // top extremes, odd associativity, zero ways with a large offset.
    phases.push_back('{4'd6, 3'd6, 4'd8, 1'b0, 1'b1, 1'b0});
    phases.push_back('{4'd6, 3'd6, 4'd8, 1'b1, 1'b1, 1'b1});
    phases.push_back('{4'd0, 3'd0, 4'd1, 1'b1, 1'b0, 1'b0});
    phases.push_back('{4'd15, 3'd7, 4'd15, 1'b0, 1'b1, 1'b0});
    phases.push_back('{4'd4, 3'd3, 4'd3, 1'b1, 1'b1, 1'b0});
    phases.push_back('{4'd13, 3'd2, 4'd0, 1'b0, 1'b1, 1'b0});
    phases.push_back('{4'd12, 3'd6, 4'd4, 1'b1, 1'b0, 1'b0});
    phases.push_back('{4'd2, 3'd1, 4'd2, 1'b0, 1'b1, 1'b0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_access(directed[i]);

    foreach (phases[p]) begin
      ph = phases[p];
      drain_results();
      write_reg(RegOffsetBits, ph.ob);
      write_reg(RegIndexBits, 4'(ph.ib));
      write_reg(RegWaysInUse, ph.ways);
      write_reg(RegLruMode, 4'(ph.lru));
      write_reg(RegPrefetchEn, 4'(ph.pf));
      if (p == 0) write_reg(RegUnused, 4'hF);
      quiet_sender = ph.no_idle;
      quiet_receiver = ph.no_idle;
      // Prefetch of the top block wraps to address zero.
      row = '{1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 2'd0, 1'b0};
      send_access(row);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 3 && n == ItemsPerPhase / 2) drain_results();
        row = '{logic'($urandom_range(0, 1)), pick_address(), 1'b0, 1'b0, 2'd0, 1'b0};
        send_access(row);
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/sac_pkg.sv
design/sac_ram.sv
design/set_assoc_cache_with_prefetch.sv
test/testbench.sv
